// ----- rtl/pli_pkg.sv -----
// ----------------------------------------------------------------------------
// pli_pkg: shared types and codes for the positional list
// Operation codes, result status codes and the move command that the list
// controller broadcasts to every storage cell in the chain.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int POS_W  = 5;
    localparam int STAT_W = 3;

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_INS_ERR = 3'd1;
    localparam logic [STAT_W-1:0] ST_DEL_ERR = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd4;

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_INSERT,
        MODE_DELETE,
        MODE_ROTATE
    } t_cell_mode;

endpackage

// ----- rtl/positional_list_insert_delete.sv -----
// ----------------------------------------------------------------------------
// positional_list_insert_delete: ordered list with insert and delete by place
// Keeps up to CAPACITY signed elements in a chain of shifting cells and
// serves clear, append, insert, delete and dump commands.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Handshake
//  command   i_op, i_position, i_value               start, taken when !busy
//  result    o_status, o_element, o_last             o_strobe, one cycle each
//
// Clear, append, insert, delete and the empty dump give one result in the
// cycle after the command is taken; the cell chain shifts at the same edge.
// A dump of more than one element holds busy in S_DUMP and streams one
// element a cycle from the head as the chain rotates once around.
// Reset empties the list; the stored values themselves are not cleared.
// Results cannot be stalled by the receiver.
module positional_list_insert_delete
    import pli_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_op,
    input  logic [POS_W-1:0]  i_position,
    input  logic [DATA_W-1:0] i_value,
    output logic              o_strobe,
    output logic [STAT_W-1:0] o_status,
    output logic [DATA_W-1:0] o_element,
    output logic              o_last
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = (LW > POS_W) ? LW : POS_W;

    typedef logic [CW-1:0] t_cw;
    typedef enum logic {S_IDLE, S_DUMP} t_state;

    t_state            r_state, n_state;
    logic [LW-1:0]     r_len, n_len;
    logic [LW-1:0]     r_cnt, n_cnt;
    logic              r_strobe, n_strobe;
    logic [STAT_W-1:0] r_status, n_status;
    logic [DATA_W-1:0] r_element, n_element;
    logic              r_last, n_last;

    t_cell_mode        w_mode;
    logic [LW-1:0]     w_slot;
    logic [DATA_W-1:0] w_val  [CAPACITY];
    logic [DATA_W-1:0] w_pick [CAPACITY];
    logic [DATA_W-1:0] w_picked;
    t_cw               w_pos, w_len, w_ins_slot;
    logic              w_full;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_W-1:0] w_prev, w_next;
        if (k == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid
            assign w_prev = w_val[k-1];
        end
        if (k == CAPACITY - 1) begin : g_end
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_val[k+1];
        end
        pli_cell #(
            .INDEX (k),
            .LW    (LW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_mode   (w_mode),
            .i_slot   (w_slot),
            .i_length (r_len),
            .i_value  (i_value),
            .i_prev   (w_prev),
            .i_next   (w_next),
            .i_head   (w_val[0]),
            .o_value  (w_val[k]),
            .o_pick   (w_pick[k])
        );
    end

    always_comb begin
        w_picked = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_picked = w_picked | w_pick[k];
        end
    end

    assign w_pos      = t_cw'(i_position);
    assign w_len      = t_cw'(r_len);
    assign w_ins_slot = (i_position == '0) ? '0 : (w_pos - t_cw'(1));
    assign w_full     = (r_len == LW'(CAPACITY));

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_strobe  = 1'b0;
        n_status  = ST_OK;
        n_element = '0;
        n_last    = 1'b1;
        w_mode    = MODE_HOLD;
        w_slot    = r_len;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_op)
                        OP_CLEAR: begin
                            n_strobe = 1'b1;
                            n_len    = '0;
                        end
                        OP_APPEND: begin
                            n_strobe = 1'b1;
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_mode = MODE_INSERT;
                                w_slot = r_len;
                                n_len  = r_len + LW'(1);
                            end
                        end
                        OP_INSERT: begin
                            n_strobe = 1'b1;
                            if (w_ins_slot > w_len) begin
                                n_status = ST_INS_ERR;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_mode = MODE_INSERT;
                                w_slot = w_ins_slot[LW-1:0];
                                n_len  = r_len + LW'(1);
                            end
                        end
                        OP_DELETE: begin
                            n_strobe = 1'b1;
                            if ((i_position == '0) || (w_pos > w_len)) begin
                                n_status = ST_DEL_ERR;
                            end else begin
                                w_mode    = MODE_DELETE;
                                w_slot    = w_ins_slot[LW-1:0];
                                n_element = w_picked;
                                n_len     = r_len - LW'(1);
                            end
                        end
                        OP_DUMP: begin
                            n_strobe = 1'b1;
                            if (r_len == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                w_mode    = MODE_ROTATE;
                                n_element = w_val[0];
                                n_cnt     = LW'(1);
                                if (r_len == LW'(1)) begin
                                    n_last = 1'b1;
                                end else begin
                                    n_last  = 1'b0;
                                    n_state = S_DUMP;
                                end
                            end
                        end
                        default: begin
                            n_strobe = 1'b0;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                w_mode    = MODE_ROTATE;
                n_strobe  = 1'b1;
                n_element = w_val[0];
                n_cnt     = r_cnt + LW'(1);
                if (r_cnt == (r_len - LW'(1))) begin
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_last = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
        r_status  <= n_status;
        r_element <= n_element;
        r_last    <= n_last;
    end

    assign busy      = (r_state == S_DUMP);
    assign o_strobe  = r_strobe;
    assign o_status  = r_status;
    assign o_element = r_element;
    assign o_last    = r_last;

endmodule

// ----- rtl/pli_cell.sv -----
// ----------------------------------------------------------------------------
// pli_cell: one storage cell of the positional list chain
// Holds one element and moves it to or from its neighbors according to the
// broadcast command, its own position, the target slot and the list length.
// ----------------------------------------------------------------------------
module pli_cell
    import pli_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int LW    = 5
) (
    input  logic              i_clk,
    input  t_cell_mode        i_mode,
    input  logic [LW-1:0]     i_slot,
    input  logic [LW-1:0]     i_length,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_prev,
    input  logic [DATA_W-1:0] i_next,
    input  logic [DATA_W-1:0] i_head,
    output logic [DATA_W-1:0] o_value,
    output logic [DATA_W-1:0] o_pick
);

    localparam logic [LW-1:0] K  = LW'(INDEX);
    localparam logic [LW-1:0] K1 = LW'(INDEX + 1);

    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_mode)
            MODE_INSERT: begin
                if (K == i_slot) begin
                    n_value = i_value;
                end else if ((K > i_slot) && (K <= i_length)) begin
                    n_value = i_prev;
                end
            end
            MODE_DELETE: begin
                if ((K >= i_slot) && (K1 < i_length)) begin
                    n_value = i_next;
                end
            end
            MODE_ROTATE: begin
                if (K1 == i_length) begin
                    n_value = i_head;
                end else begin
                    n_value = i_next;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_pick  = (K == i_slot) ? r_value : '0;

endmodule
